[rtl/core/omni_wheel_speed_mixer_unit_defines.svh]
// assertion macros for the omni wheel speed mixer
`ifndef OMNI_WHEEL_SPEED_MIXER_UNIT_DEFINES_SVH
`define OMNI_WHEEL_SPEED_MIXER_UNIT_DEFINES_SVH
`ifndef SYNTH
`define OWSM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define OWSM_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OWSM_ASSERT(lbl, clk, rstn, prop, msg)
`define OWSM_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

[rtl/core/owsm_pkg.sv]
`timescale 1ns / 1ps
package owsm_pkg;

    localparam int WHEEL_COUNT = 4;
    localparam int REM_W       = 18;
    localparam int DIV_STEPS   = 3;

    localparam logic [6:0] SPEED_LIMIT_RESET = 7'd100;
    localparam logic [1:0] DUTY_SCALE_RESET  = 2'd2;

    localparam logic [1:0] REG_SPEED_LIMIT = 2'd0;
    localparam logic [1:0] REG_DUTY_SCALE  = 2'd1;

    typedef struct packed {
        logic [1:0]  idx;
        logic        last;
        logic        fwd;
        logic        rev;
        logic        zero;
        logic        scaled;
        logic [10:0] duty_lin;
    } wheel_ctl_t;

    function automatic logic [15:0] sine_q15(input logic [6:0] idx);
        logic [15:0] v;
        case (idx)
            7'd0: v = 16'd0;         7'd1: v = 16'd572;       7'd2: v = 16'd1144;
            7'd3: v = 16'd1715;      7'd4: v = 16'd2286;      7'd5: v = 16'd2856;
            7'd6: v = 16'd3425;      7'd7: v = 16'd3993;      7'd8: v = 16'd4560;
            7'd9: v = 16'd5126;      7'd10: v = 16'd5690;     7'd11: v = 16'd6252;
            7'd12: v = 16'd6813;     7'd13: v = 16'd7371;     7'd14: v = 16'd7927;
            7'd15: v = 16'd8481;     7'd16: v = 16'd9032;     7'd17: v = 16'd9580;
            7'd18: v = 16'd10126;    7'd19: v = 16'd10668;    7'd20: v = 16'd11207;
            7'd21: v = 16'd11743;    7'd22: v = 16'd12275;    7'd23: v = 16'd12803;
            7'd24: v = 16'd13328;    7'd25: v = 16'd13848;    7'd26: v = 16'd14365;
            7'd27: v = 16'd14876;    7'd28: v = 16'd15384;    7'd29: v = 16'd15886;
            7'd30: v = 16'd16384;    7'd31: v = 16'd16877;    7'd32: v = 16'd17364;
            7'd33: v = 16'd17847;    7'd34: v = 16'd18324;    7'd35: v = 16'd18795;
            7'd36: v = 16'd19261;    7'd37: v = 16'd19720;    7'd38: v = 16'd20174;
            7'd39: v = 16'd20622;    7'd40: v = 16'd21063;    7'd41: v = 16'd21498;
            7'd42: v = 16'd21926;    7'd43: v = 16'd22348;    7'd44: v = 16'd22763;
            7'd45: v = 16'd23170;    7'd46: v = 16'd23571;    7'd47: v = 16'd23965;
            7'd48: v = 16'd24351;    7'd49: v = 16'd24730;    7'd50: v = 16'd25102;
            7'd51: v = 16'd25466;    7'd52: v = 16'd25822;    7'd53: v = 16'd26170;
            7'd54: v = 16'd26510;    7'd55: v = 16'd26842;    7'd56: v = 16'd27166;
            7'd57: v = 16'd27482;    7'd58: v = 16'd27789;    7'd59: v = 16'd28088;
            7'd60: v = 16'd28378;    7'd61: v = 16'd28660;    7'd62: v = 16'd28932;
            7'd63: v = 16'd29197;    7'd64: v = 16'd29452;    7'd65: v = 16'd29698;
            7'd66: v = 16'd29935;    7'd67: v = 16'd30163;    7'd68: v = 16'd30382;
            7'd69: v = 16'd30592;    7'd70: v = 16'd30792;    7'd71: v = 16'd30983;
            7'd72: v = 16'd31164;    7'd73: v = 16'd31336;    7'd74: v = 16'd31499;
            7'd75: v = 16'd31651;    7'd76: v = 16'd31795;    7'd77: v = 16'd31928;
            7'd78: v = 16'd32052;    7'd79: v = 16'd32166;    7'd80: v = 16'd32270;
            7'd81: v = 16'd32365;    7'd82: v = 16'd32449;    7'd83: v = 16'd32524;
            7'd84: v = 16'd32588;    7'd85: v = 16'd32643;    7'd86: v = 16'd32688;
            7'd87: v = 16'd32723;    7'd88: v = 16'd32748;    7'd89: v = 16'd32763;
            7'd90: v = 16'd32768;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    // cosine of 0..359 degrees, 1.0 = 32768
    function automatic logic signed [16:0] cos_q15(input logic [8:0] a);
        logic [8:0]  idx;
        logic        neg;
        logic [15:0] mag;
        if (a <= 9'd90)
        begin
            idx = 9'd90 - a;
            neg = 1'b0;
        end
        else if (a <= 9'd180)
        begin
            idx = a - 9'd90;
            neg = 1'b1;
        end
        else if (a <= 9'd270)
        begin
            idx = 9'd270 - a;
            neg = 1'b1;
        end
        else
        begin
            idx = a - 9'd270;
            neg = 1'b0;
        end
        mag = sine_q15(idx[6:0]);
        return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

endpackage

[rtl/core/owsm_div_step.sv]
`timescale 1ns / 1ps
module owsm_div_step #(
    parameter int REM_W = owsm_pkg::REM_W,
    parameter int STEPS = owsm_pkg::DIV_STEPS
) (
    input  logic [REM_W-1:0] rem_in,
    input  logic [REM_W-1:0] den,
    input  logic [STEPS-1:0] bits_in,
    output logic [REM_W-1:0] rem_out,
    output logic [STEPS-1:0] q_out
);

    always_comb
    begin
        logic [REM_W:0]   s;
        logic [REM_W-1:0] r;
        r = rem_in;
        q_out = '0;
        for (int k = 0; k < STEPS; k++)
        begin
            s = {r, bits_in[STEPS-1-k]};
            if (s >= {1'b0, den})
            begin
                s = s - {1'b0, den};
                q_out[STEPS-1-k] = 1'b1;
            end
            r = s[REM_W-1:0];
        end
        rem_out = r;
    end

endmodule

[rtl/core/omni_wheel_speed_mixer_unit.sv]
`timescale 1ns / 1ps
// Four-wheel omni drive mixer. A request of heading, speed and turn correction yields
// four wheel results in wheel order, one per cycle unless out_stall holds them, the
// last flagged by last_wheel. A request passes stages a to d, the serializer, w0 and
// q1 to q3; the shared divider lane takes one wheel per cycle unless stalled, so a
// request leaves the serializer after its last wheel. in_stall is high while stage a
// waits on a serializer holding an earlier request. cfg_ready is always high.
`include "omni_wheel_speed_mixer_unit_defines.svh"
module omni_wheel_speed_mixer_unit #(
    parameter int WHEEL_COUNT = owsm_pkg::WHEEL_COUNT,
    parameter int REM_W       = owsm_pkg::REM_W,
    parameter int DIV_STEPS   = owsm_pkg::DIV_STEPS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [8:0]        heading_deg,
    input  logic signed [8:0] travel_speed,
    input  logic signed [8:0] turn_correction,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        wheel_index,
    output logic              drive_forward,
    output logic              drive_reverse,
    output logic [7:0]        duty,
    output logic              last_wheel,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [6:0]        cfg_data
);

    localparam int CNT_W = (WHEEL_COUNT > 1) ? $clog2(WHEEL_COUNT) : 1;
    localparam int LOW_W = 3 * DIV_STEPS;

    // configuration
    logic [6:0] speed_limit_reg;
    logic [1:0] duty_scale_reg;
    logic [8:0] dl;

    assign cfg_ready = 1'b1;
    assign dl = 9'(speed_limit_reg * duty_scale_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_limit_reg <= owsm_pkg::SPEED_LIMIT_RESET;
            duty_scale_reg  <= owsm_pkg::DUTY_SCALE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                owsm_pkg::REG_SPEED_LIMIT: speed_limit_reg <= cfg_data;
                owsm_pkg::REG_DUTY_SCALE:  duty_scale_reg  <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // stage valids and ready chain
    logic a_v_reg, b_v_reg, c_v_reg, d_v_reg, ser_v_reg, w0_v_reg;
    logic q1_v_reg, q2_v_reg, q3_v_reg, out_v_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic out_rdy, q3_rdy, q2_rdy, q1_rdy, w0_rdy, ser_rdy, d_rdy, c_rdy, b_rdy, a_rdy;
    logic ser_last;

    assign ser_last = (cnt_reg == CNT_W'(WHEEL_COUNT - 1));
    assign out_rdy  = !out_v_reg || !out_stall;
    assign q3_rdy   = !q3_v_reg || out_rdy;
    assign q2_rdy   = !q2_v_reg || q3_rdy;
    assign q1_rdy   = !q1_v_reg || q2_rdy;
    assign w0_rdy   = !w0_v_reg || q1_rdy;
    assign ser_rdy  = !ser_v_reg || (w0_rdy && ser_last);
    assign d_rdy    = !d_v_reg || ser_rdy;
    assign c_rdy    = !c_v_reg || d_rdy;
    assign b_rdy    = !b_v_reg || c_rdy;
    assign a_rdy    = !a_v_reg || b_rdy;
    assign in_stall = !a_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg   <= 1'b0;
            b_v_reg   <= 1'b0;
            c_v_reg   <= 1'b0;
            d_v_reg   <= 1'b0;
            ser_v_reg <= 1'b0;
            cnt_reg   <= '0;
            w0_v_reg  <= 1'b0;
            q1_v_reg  <= 1'b0;
            q2_v_reg  <= 1'b0;
            q3_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (a_rdy)
            begin
                a_v_reg <= in_valid;
            end
            if (b_rdy)
            begin
                b_v_reg <= a_v_reg;
            end
            if (c_rdy)
            begin
                c_v_reg <= b_v_reg;
            end
            if (d_rdy)
            begin
                d_v_reg <= c_v_reg;
            end
            if (ser_rdy)
            begin
                ser_v_reg <= d_v_reg;
                cnt_reg   <= '0;
            end
            else if (ser_v_reg && w0_rdy)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (w0_rdy)
            begin
                w0_v_reg <= ser_v_reg;
            end
            if (q1_rdy)
            begin
                q1_v_reg <= w0_v_reg;
            end
            if (q2_rdy)
            begin
                q2_v_reg <= q1_v_reg;
            end
            if (q3_rdy)
            begin
                q3_v_reg <= q2_v_reg;
            end
            if (out_rdy)
            begin
                out_v_reg <= q3_v_reg;
            end
        end
    end

    // stage a: heading reduction plus mount offset
    logic [8:0]        a_ang_reg;
    logic signed [8:0] a_speed_reg, a_corr_reg;
    logic [8:0]        h_mod;
    logic [9:0]        h_off;

    assign h_mod = (heading_deg >= 9'd360) ? heading_deg - 9'd360 : heading_deg;
    assign h_off = {1'b0, h_mod} + 10'd45;

    always_ff @(posedge clk)
    begin
        if (a_rdy)
        begin
            a_ang_reg   <= (h_off >= 10'd360) ? 9'(h_off - 10'd360) : h_off[8:0];
            a_speed_reg <= travel_speed;
            a_corr_reg  <= turn_correction;
        end
    end

    // stages b to d: per-wheel lanes
    logic signed [16:0] b_cos_reg [WHEEL_COUNT];
    logic signed [8:0]  b_speed_reg, b_corr_reg, c_corr_reg;
    logic signed [25:0] c_prod_reg [WHEEL_COUNT];
    logic signed [17:0] d_w_reg [WHEEL_COUNT];
    logic [16:0]        d_mag_reg [WHEEL_COUNT];

    always_ff @(posedge clk)
    begin
        if (b_rdy)
        begin
            b_speed_reg <= a_speed_reg;
            b_corr_reg  <= a_corr_reg;
        end
        if (c_rdy)
        begin
            c_corr_reg <= b_corr_reg;
        end
    end

    for (genvar i = 0; i < WHEEL_COUNT; i++)
    begin : g_lane
        localparam int OFF = (270 * i) % 360;
        logic [9:0]         t;
        logic [8:0]         ang;
        logic [24:0]        pm;
        logic [16:0]        r;
        logic signed [18:0] v;

        assign t   = {1'b0, a_ang_reg} + 10'(OFF);
        assign ang = (t >= 10'd360) ? 9'(t - 10'd360) : t[8:0];
        assign pm  = c_prod_reg[i][25] ? 25'(-c_prod_reg[i]) : c_prod_reg[i][24:0];
        assign r   = 17'((pm + 25'd64) >> 7);
        assign v   = (c_prod_reg[i][25] ? -$signed({2'b00, r}) : $signed({2'b00, r}))
                     - ($signed({{2{c_corr_reg[8]}}, c_corr_reg, 8'b0}));

        always_ff @(posedge clk)
        begin
            if (b_rdy)
            begin
                b_cos_reg[i] <= owsm_pkg::cos_q15(ang);
            end
            if (c_rdy)
            begin
                c_prod_reg[i] <= b_speed_reg * b_cos_reg[i];
            end
            if (d_rdy)
            begin
                d_w_reg[i]   <= v[17:0];
                d_mag_reg[i] <= v[18] ? 17'(-v) : v[16:0];
            end
        end
    end

    // serializer: holds one request, largest magnitude and scale decision
    logic signed [17:0] ser_w_reg [WHEEL_COUNT];
    logic [16:0]        ser_mag_reg [WHEEL_COUNT];
    logic [16:0]        ser_high_reg;
    logic               ser_scaled_reg;
    logic [16:0]        high;

    always_comb
    begin
        high = '0;
        for (int k = 0; k < WHEEL_COUNT; k++)
        begin
            if (d_mag_reg[k] > high)
            begin
                high = d_mag_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ser_rdy)
        begin
            ser_w_reg      <= d_w_reg;
            ser_mag_reg    <= d_mag_reg;
            ser_high_reg   <= high;
            ser_scaled_reg <= high > {speed_limit_reg, 8'b0};
        end
    end

    // w0: wheel selection, numerator and linear duty
    logic [26:0]            w0_num_reg;
    logic [REM_W-1:0]       w0_den_reg;
    owsm_pkg::wheel_ctl_t   w0_ctl_reg;
    logic [16:0]            sel_mag;
    logic signed [17:0]     sel_w;
    logic                   sel_zero;
    owsm_pkg::wheel_ctl_t   w0_ctl_next;

    assign sel_mag  = ser_mag_reg[cnt_reg];
    assign sel_w    = ser_w_reg[cnt_reg];
    assign sel_zero = (sel_w == '0) || (ser_scaled_reg && speed_limit_reg == 7'd0);

    always_comb
    begin
        w0_ctl_next.idx      = 2'(cnt_reg);
        w0_ctl_next.last     = ser_last;
        w0_ctl_next.zero     = sel_zero;
        w0_ctl_next.fwd      = !sel_zero && !sel_w[17];
        w0_ctl_next.rev      = !sel_zero && sel_w[17];
        w0_ctl_next.scaled   = ser_scaled_reg;
        w0_ctl_next.duty_lin = 11'((19'(sel_mag * duty_scale_reg) + 19'd128) >> 8);
    end

    always_ff @(posedge clk)
    begin
        if (w0_rdy)
        begin
            w0_num_reg <= 27'({sel_mag, 1'b0} * dl) + 27'(ser_high_reg);
            w0_den_reg <= REM_W'({ser_high_reg, 1'b0});
            w0_ctl_reg <= w0_ctl_next;
        end
    end

    // divider lane, three quotient bits per stage
    logic [REM_W-1:0]       q1_rem_reg, q2_rem_reg, q3_rem_reg;
    logic [REM_W-1:0]       q1_den_reg, q2_den_reg;
    logic [LOW_W-1:0]       q1_q_reg, q2_q_reg, q3_q_reg;
    logic [LOW_W-1:0]       q1_low_reg, q2_low_reg;
    owsm_pkg::wheel_ctl_t   q1_ctl_reg, q2_ctl_reg, q3_ctl_reg;
    logic [REM_W-1:0]       r1, r2, r3;
    logic [DIV_STEPS-1:0]   d1, d2, d3;

    owsm_div_step #(.REM_W(REM_W), .STEPS(DIV_STEPS)) u_div1 (
        .rem_in  (REM_W'(w0_num_reg >> LOW_W)),
        .den     (w0_den_reg),
        .bits_in (w0_num_reg[LOW_W-1 -: DIV_STEPS]),
        .rem_out (r1),
        .q_out   (d1)
    );

    owsm_div_step #(.REM_W(REM_W), .STEPS(DIV_STEPS)) u_div2 (
        .rem_in  (q1_rem_reg),
        .den     (q1_den_reg),
        .bits_in (q1_low_reg[LOW_W-1 -: DIV_STEPS]),
        .rem_out (r2),
        .q_out   (d2)
    );

    owsm_div_step #(.REM_W(REM_W), .STEPS(DIV_STEPS)) u_div3 (
        .rem_in  (q2_rem_reg),
        .den     (q2_den_reg),
        .bits_in (q2_low_reg[LOW_W-1 -: DIV_STEPS]),
        .rem_out (r3),
        .q_out   (d3)
    );

    always_ff @(posedge clk)
    begin
        if (q1_rdy)
        begin
            q1_rem_reg <= r1;
            q1_den_reg <= w0_den_reg;
            q1_q_reg   <= LOW_W'(d1);
            q1_low_reg <= LOW_W'({w0_num_reg[LOW_W-1:0], {DIV_STEPS{1'b0}}});
            q1_ctl_reg <= w0_ctl_reg;
        end
        if (q2_rdy)
        begin
            q2_rem_reg <= r2;
            q2_den_reg <= q1_den_reg;
            q2_q_reg   <= LOW_W'({q1_q_reg, d2});
            q2_low_reg <= LOW_W'({q1_low_reg, {DIV_STEPS{1'b0}}});
            q2_ctl_reg <= q1_ctl_reg;
        end
        if (q3_rdy)
        begin
            q3_rem_reg <= r3;
            q3_q_reg   <= LOW_W'({q2_q_reg, d3});
            q3_ctl_reg <= q2_ctl_reg;
        end
    end

    // output register
    logic [1:0] out_idx_reg;
    logic       out_fwd_reg, out_rev_reg, out_last_reg;
    logic [7:0] out_duty_reg;
    logic [7:0] duty_next;

    always_comb
    begin
        if (q3_ctl_reg.zero)
        begin
            duty_next = 8'd0;
        end
        else if (q3_ctl_reg.scaled)
        begin
            duty_next = (q3_q_reg > LOW_W'(255)) ? 8'd255 : q3_q_reg[7:0];
        end
        else
        begin
            duty_next = (q3_ctl_reg.duty_lin > 11'd255) ? 8'd255 : q3_ctl_reg.duty_lin[7:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_rdy)
        begin
            out_idx_reg  <= q3_ctl_reg.idx;
            out_fwd_reg  <= q3_ctl_reg.fwd;
            out_rev_reg  <= q3_ctl_reg.rev;
            out_last_reg <= q3_ctl_reg.last;
            out_duty_reg <= duty_next;
        end
    end

    assign out_valid     = out_v_reg;
    assign wheel_index   = out_idx_reg;
    assign drive_forward = out_fwd_reg;
    assign drive_reverse = out_rev_reg;
    assign duty          = out_duty_reg;
    assign last_wheel    = out_last_reg;

    `OWSM_ASSERT(a_last_idx, clk, rst_n, out_valid && last_wheel |-> wheel_index == 2'd3, "last wheel index")
    `OWSM_ASSERT(a_dir_duty, clk, rst_n, out_valid && !drive_forward && !drive_reverse |-> duty == 8'd0, "idle wheel duty")
    `OWSM_ASSERT(a_cnt_hold, clk, rst_n, ser_v_reg && !w0_rdy |=> $stable(cnt_reg), "serializer slipped")
    `OWSM_ASSERT_RST(a_rst_out, clk, !rst_n |-> !out_valid, "output valid in reset")

endmodule
